[rtl/afc_pkg.sv]
// Package for the acknowledgement frame checker.
// Holds the header constants, CRC constants, register indexes and the result type.
// Depends on nothing.
package afc_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  HDR_MAGIC   = 8'hA5;
    localparam logic [7:0]  HDR_VERSION = 8'h01;
    localparam logic [7:0]  HDR_ACK     = 8'h20;
    localparam logic [7:0]  HDR_LENGTH  = 8'h00;
    localparam int          MIN_FRAME   = 8;
    localparam int          HDR_BYTES   = 6;
    localparam int          CRC_START   = 2;

    localparam int          CFG_IDX_W    = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQ = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENDER_ID    = 8'd1;
    localparam logic [7:0]  SENDER_ID_RESET    = 8'hF0;
    localparam logic [7:0]  EXPECTED_SEQ_RESET = 8'h00;

    localparam int          LEN_W = 5;

    typedef struct packed {
        logic             ack_valid;
        logic [LEN_W-1:0] frame_length;
    } afc_result_t;

endpackage

[rtl/afc_crc_step.sv]
// One byte of CRC-16 update, polynomial 0x1021, MSB first.
// Combinational, eight unrolled bit steps. Depends on afc_pkg.
module afc_crc_step (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import afc_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

[rtl/afc_frame_track.sv]
// Per-frame state: tail delay line, running CRC, byte count and header match.
// Produces the verdict for the byte presented on step. Depends on afc_pkg, afc_crc_step.
module afc_frame_track #(
    parameter int MAX_FRAME = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [7:0]           expected_seq,
    input  logic [7:0]           sender_id,
    output afc_pkg::afc_result_t result
);
    import afc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 2);

    logic [7:0]    tail0_reg, tail0_next;
    logic [7:0]    tail1_reg, tail1_next;
    logic [15:0]   crc_reg, crc_next;
    logic [CW-1:0] count_reg, count_next;
    logic          hdr_reg, hdr_next;

    logic [7:0]    want;
    logic [15:0]   crc_upd;
    logic [15:0]   crc_cur;
    logic [CW-1:0] count_inc;
    logic          hdr_cur;
    logic          ok;

    afc_crc_step u_crc (
        .crc_in  (crc_reg),
        .data    (tail1_reg),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        unique case (count_reg[2:0])
            3'd0:    want = HDR_MAGIC;
            3'd1:    want = HDR_VERSION;
            3'd2:    want = HDR_ACK;
            3'd3:    want = sender_id;
            3'd4:    want = expected_seq;
            default: want = HDR_LENGTH;
        endcase
    end

    assign hdr_cur   = hdr_reg & ((count_reg >= CW'(HDR_BYTES)) | (data_byte == want));
    assign crc_cur   = (count_reg >= CW'(CRC_START)) ? crc_upd : crc_reg;
    assign count_inc = (count_reg < CW'(MAX_FRAME + 1)) ? count_reg + CW'(1) : count_reg;

    assign ok = (count_inc >= CW'(MIN_FRAME)) && (count_inc <= CW'(MAX_FRAME)) && hdr_cur
                && ({tail0_reg, data_byte} == crc_cur);

    assign result.ack_valid    = ok;
    assign result.frame_length = LEN_W'(count_inc);

    always_comb
    begin
        tail0_next = tail0_reg;
        tail1_next = tail1_reg;
        crc_next   = crc_reg;
        count_next = count_reg;
        hdr_next   = hdr_reg;
        if (step)
        begin
            if (last_byte)
            begin
                tail0_next = 8'h00;
                tail1_next = 8'h00;
                crc_next   = CRC_INIT;
                count_next = '0;
                hdr_next   = 1'b1;
            end
            else
            begin
                tail0_next = data_byte;
                tail1_next = tail0_reg;
                crc_next   = crc_cur;
                count_next = count_inc;
                hdr_next   = hdr_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail0_reg <= 8'h00;
            tail1_reg <= 8'h00;
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            hdr_reg   <= 1'b1;
        end
        else
        begin
            tail0_reg <= tail0_next;
            tail1_reg <= tail1_next;
            crc_reg   <= crc_next;
            count_reg <= count_next;
            hdr_reg   <= hdr_next;
        end
    end

endmodule

[rtl/ack_frame_checker_core.sv]
// Acknowledgement frame checker top level: input register, frame tracker, result register.
// Depends on afc_pkg, afc_frame_track, afc_crc_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one frame byte per request with
//   last_byte marking the final byte. Output channel (out_valid/out_ready) gives
//   one request per frame: ack_valid and frame_length. Configuration channel
//   (cfg_valid/cfg_ready) writes expected_seq (index 0) or sender_id (index 1);
//   other indexes are ignored. cfg_ready is always high; write only while idle.
//   A byte accepted into the input register is checked when it leaves that
//   register; for a last byte the verdict is registered into the result
//   register at the same time and out_valid rises with it.
//   Throughput: one byte per cycle while no last byte is held (see Stall);
//   the byte-wide CRC update is combinational.
//   Stall: while a result waits, non-last bytes still flow; a last byte holds in
//   the input register and in_ready drops until the result is taken.
//   Reset: all channels empty, CRC at 0xFFFF, count zero, expected_seq 0,
//   sender_id 0xF0.
module ack_frame_checker_core #(
    parameter int MAX_FRAME = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ack_valid,
    output logic [afc_pkg::LEN_W-1:0]     frame_length,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import afc_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_data_reg;
    logic             s1_last_reg;
    logic             out_valid_reg, out_valid_next;
    logic             ack_valid_reg;
    logic [LEN_W-1:0] frame_length_reg;
    logic [7:0]       expected_seq_reg;
    logic [7:0]       sender_id_reg;

    logic             out_free;
    logic             s1_adv;
    logic             in_take;
    afc_result_t      result;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    assign cfg_ready = 1'b1;

    afc_frame_track #(
        .MAX_FRAME (MAX_FRAME)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_adv),
        .data_byte    (s1_data_reg),
        .last_byte    (s1_last_reg),
        .expected_seq (expected_seq_reg),
        .sender_id    (sender_id_reg),
        .result       (result)
    );

    always_comb
    begin
        s1_valid_next = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        if (s1_adv && s1_last_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            expected_seq_reg <= EXPECTED_SEQ_RESET;
            sender_id_reg    <= SENDER_ID_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EXPECTED_SEQ)
                    expected_seq_reg <= cfg_data;
                else if (cfg_index == CFG_SENDER_ID)
                    sender_id_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_adv && s1_last_reg)
        begin
            ack_valid_reg    <= result.ack_valid;
            frame_length_reg <= result.frame_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ack_valid    = ack_valid_reg;
    assign frame_length = frame_length_reg;

    a_last_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |-> !out_valid_reg || out_ready)
        else $error("last byte advanced over a pending result");

    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result raised without a last byte");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_last_reg)
        else $error("input stalled with an empty or non-last input stage");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ack_valid_reg |-> (MAX_FRAME > 30)
        || (frame_length_reg >= LEN_W'(MIN_FRAME)))
        else $error("accepted frame shorter than minimum");

endmodule

[tb/ack_frame_checker_core_tb.sv]
// Self-checking testbench for ack_frame_checker_core: well-formed, corrupted, short,
// long and noise frames under bursty input and stalling output, across register settings.
// Depends on afc_pkg and the ack_frame_checker_core RTL.
`timescale 1ns / 100ps

module ack_frame_checker_core_tb;

    import afc_pkg::*;

    localparam int MAX_FRAME   = 16;
    localparam int HOLD_CYCLES = 90;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 180;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;
    typedef enum logic [1:0] {FR_GOOD, FR_BAD_HDR, FR_BAD_CRC, FR_NOISE} frame_kind_t;

    class ack_verdict_model #(int unsigned MAX_LEN = 16);
        logic [7:0]  exp_seq;
        logic [7:0]  gw_id;
        logic [7:0]  tail [2];
        logic [15:0] crc;
        int unsigned count;
        bit          hdr_ok;
        afc_result_t pending_verdicts [$];
        int unsigned errors;
        int unsigned frames_ok;
        int unsigned frames_rejected;

        function new();
            exp_seq = EXPECTED_SEQ_RESET;
            gw_id   = SENDER_ID_RESET;
            errors  = 0;
            frames_ok = 0;
            frames_rejected = 0;
            rearm();
        endfunction

        function void rearm();
            tail[0] = 8'h00;
            tail[1] = 8'h00;
            crc     = CRC_INIT;
            count   = 0;
            hdr_ok  = 1'b1;
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            for (int k = 0; k < 8; k++)
                r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            return r;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_EXPECTED_SEQ)
                exp_seq = val;
            else if (idx == CFG_SENDER_ID)
                gw_id = val;
        endfunction

        function void take_byte(logic [7:0] b, logic lst);
            logic [7:0]  want;
            logic [15:0] rx_crc;
            afc_result_t r;
            if (count < HDR_BYTES)
            begin
                case (count)
                    0:       want = HDR_MAGIC;
                    1:       want = HDR_VERSION;
                    2:       want = HDR_ACK;
                    3:       want = gw_id;
                    4:       want = exp_seq;
                    default: want = HDR_LENGTH;
                endcase
                if (b != want)
                    hdr_ok = 1'b0;
            end
            if (count >= CRC_START)
                crc = crc_step(crc, tail[1]);
            rx_crc  = {tail[0], b};
            tail[1] = tail[0];
            tail[0] = b;
            if (count < MAX_LEN + 1)
                count++;
            if (lst)
            begin
                r.frame_length = count[LEN_W-1:0];
                r.ack_valid    = count >= MIN_FRAME && count <= MAX_LEN && hdr_ok &&
                                 rx_crc == crc;
                if (r.ack_valid)
                    frames_ok++;
                else
                    frames_rejected++;
                pending_verdicts.push_back(r);
                rearm();
            end
        endfunction

        function void match_verdict(logic ack, logic [LEN_W-1:0] len);
            afc_result_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected verdict: ack_valid %0d frame_length %0d", ack, len);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (want.ack_valid !== ack)
            begin
                $error("ack_valid: expected %0d, actual %0d", want.ack_valid, ack);
                errors++;
            end
            if (want.frame_length !== len)
            begin
                $error("frame_length: expected %0d, actual %0d", want.frame_length, len);
                errors++;
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           data_byte;
    logic                 last_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic                 ack_valid;
    logic [LEN_W-1:0]     frame_length;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    ack_verdict_model #(MAX_FRAME) verdicts;

    rx_style_t   rx_style;
    int unsigned hold_asks;
    int unsigned holds_done;
    int unsigned rx_tick;
    int unsigned burst_left;
    int unsigned bytes_sent;
    int unsigned reg_writes;
    int unsigned in_stalls = 0;

    ack_frame_checker_core #(
        .MAX_FRAME (MAX_FRAME)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ack_valid    (ack_valid),
        .frame_length (frame_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: stall on the current style, hold off for a long stretch on request
    initial
    begin
        out_ready  = 1'b0;
        holds_done = 0;
        rx_tick    = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_asks)
            begin
                holds_done++;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rx_tick++;
            case (rx_style)
                RX_ALWAYS: out_ready = 1'b1;
                RX_RANDOM: out_ready = $urandom_range(0, 3) != 0;
                default:   out_ready = (rx_tick % 7) < 3;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            verdicts.match_verdict(ack_valid, frame_length);
        if (rst_n && in_valid && !in_ready)
            in_stalls <= in_stalls + 1;
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        in_valid  = 1'b1;
        data_byte = b;
        last_byte = lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdicts.take_byte(b, lst);
        bytes_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // hold the input idle until every verdict is back, then let the pipeline settle
    task automatic drain();
        in_valid   = 1'b0;
        burst_left = 0;
        while (verdicts.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        verdicts.write_reg(idx, val);
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_frame(input frame_kind_t kind, input int len);
        logic [7:0]  fb [0:31];
        logic [15:0] c;
        int          pick;
        for (int i = 0; i < 32; i++)
            fb[i] = 8'($urandom_range(0, 255));
        if (kind != FR_NOISE)
        begin
            fb[0] = HDR_MAGIC;
            fb[1] = HDR_VERSION;
            fb[2] = HDR_ACK;
            fb[3] = verdicts.gw_id;
            fb[4] = verdicts.exp_seq;
            fb[5] = HDR_LENGTH;
            if (kind == FR_BAD_HDR)
            begin
                pick = $urandom_range(0, HDR_BYTES - 1);
                fb[pick] ^= 8'(1 << $urandom_range(0, 7));
            end
            if (len >= 2)
            begin
                c = CRC_INIT;
                for (int i = 0; i < len - 2; i++)
                    c = verdicts.crc_step(c, fb[i]);
                fb[len-2] = c[15:8];
                fb[len-1] = c[7:0];
            end
            if (kind == FR_BAD_CRC)
            begin
                pick = len - 1 - $urandom_range(0, 1);
                fb[pick] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        for (int i = 0; i < len; i++)
            send_byte(fb[i], i == len - 1);
    endtask

    task automatic random_frame();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            send_frame(FR_GOOD, $urandom_range(MIN_FRAME, MAX_FRAME));
        else if (sel < 65)
            send_frame(FR_BAD_HDR, $urandom_range(MIN_FRAME, MAX_FRAME));
        else if (sel < 75)
            send_frame(FR_BAD_CRC, $urandom_range(MIN_FRAME, MAX_FRAME));
        else if (sel < 82)
            send_frame(FR_GOOD, $urandom_range(1, MIN_FRAME - 1));
        else if (sel < 89)
            send_frame(FR_GOOD, $urandom_range(MAX_FRAME + 1, 30));
        else
            send_frame(FR_NOISE, $urandom_range(1, 24));
    endtask

    initial
    begin
        int unsigned target;
        verdicts   = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'h00;
        last_byte  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_EXPECTED_SEQ;
        cfg_data   = 8'h00;
        rx_style   = RX_RANDOM;
        hold_asks  = 0;
        burst_left = 0;
        bytes_sent = 0;
        reg_writes = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single-byte frame, minimum good frame, overlong frame at reset settings
        send_byte(8'hFF, 1'b1);
        send_frame(FR_GOOD, MIN_FRAME);
        send_frame(FR_GOOD, MAX_FRAME + 1);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_EXPECTED_SEQ, 8'h00);
                    write_reg(CFG_SENDER_ID, 8'h00);
                end
                1:
                begin
                    write_reg(CFG_EXPECTED_SEQ, 8'hFF);
                    write_reg(CFG_SENDER_ID, 8'hFF);
                end
                default:
                begin
                    write_reg(CFG_EXPECTED_SEQ, 8'($urandom_range(0, 255)));
                    write_reg(CFG_SENDER_ID, 8'($urandom_range(0, 255)));
                end
            endcase
            // unmapped index: must leave both registers alone
            write_reg(phase == 3 ? 8'hFF : 8'($urandom_range(2, 255)),
                      8'($urandom_range(0, 255)));
            rx_style = rx_style_t'(phase % 3);
            if (phase == 2)
                hold_asks++;
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                random_frame();
            drain();
        end

        $display("Checked %0d frames (%0d accepted, %0d rejected) from %0d bytes, %0d reg writes",
                 verdicts.frames_ok + verdicts.frames_rejected, verdicts.frames_ok,
                 verdicts.frames_rejected, bytes_sent, reg_writes);
        $display("Input back-pressure seen on %0d cycles; %0d mismatches",
                 in_stalls, verdicts.errors);
        if (verdicts.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
